// File: hdl/med_pkg.sv
// ----------------------------------------------------------------------------
// med_pkg
// Shared types, constants and helpers of the Manchester edge-interval decoder.
// ----------------------------------------------------------------------------
package med_pkg;

  // Word and field widths
  localparam int WordBits = 16;
  localparam int BitCntW  = $clog2(WordBits + 1);
  localparam int TicksW   = 16;
  localparam int PeriodW  = 16;
  localparam int ScaledW  = 24;
  localparam int StatusW  = 3;
  localparam int AddrW    = 3;
  localparam int DataW    = 32;

  // Data bit count of one word, at bit counter width
  localparam logic [BitCntW-1:0] WordCnt = BitCntW'(WordBits);

  // Class queue between front and back
  localparam int QDepth = 2;
  localparam int QPtrW  = $clog2(QDepth);
  localparam int QCntW  = $clog2(QDepth + 1);

  // Register reset values
  localparam logic [PeriodW-1:0] PeriodReset     = 16'd2880;
  localparam logic               InitParityReset = 1'b1;

  // Register indexes (paddr[2])
  localparam logic REG_BIT_PERIOD  = 1'b0;
  localparam logic REG_INIT_PARITY = 1'b1;

  // Result status codes
  typedef enum logic [StatusW-1:0] {
    ST_WAIT       = 3'd0,
    ST_BITS       = 3'd1,
    ST_PARITY     = 3'd2,
    ST_READY      = 3'd3,
    ST_ERR_LEN    = 3'd4,
    ST_ERR_STRUCT = 3'd5
  } status_t;

  // Interval classes produced by the front end
  typedef enum logic [2:0] {
    CLS_LEN_ERR,
    CLS_HALF,
    CLS_FULL,
    CLS_SYNC_15,
    CLS_SYNC_2
  } class_t;

  // Interval thresholds: period times 26, 76, 126, 176 and 226
  typedef struct packed {
    logic [ScaledW-1:0] t26;
    logic [ScaledW-1:0] t76;
    logic [ScaledW-1:0] t126;
    logic [ScaledW-1:0] t176;
    logic [ScaledW-1:0] t226;
  } thr_t;

  // Queue status seen by both ends
  typedef struct packed {
    logic full;
    logic nonempty;
  } q_status_t;

  function automatic thr_t thr_calc(input logic [PeriodW-1:0] per);
    thr_t               t;
    logic [ScaledW-1:0] p;
    p      = ScaledW'(per);
    t.t26  = p * ScaledW'(26);
    t.t76  = p * ScaledW'(76);
    t.t126 = p * ScaledW'(126);
    t.t176 = p * ScaledW'(176);
    t.t226 = p * ScaledW'(226);
    return t;
  endfunction

endpackage

// File: hdl/med_if.sv
// ----------------------------------------------------------------------------
// med_in_if / med_out_if
// Valid/ready channels for interval beats and decoded result beats.
// ----------------------------------------------------------------------------
interface med_in_if;
  logic                       valid;
  logic                       ready;
  logic [med_pkg::TicksW-1:0] interval_ticks;

  modport source (output valid, output interval_ticks, input ready);
  modport sink (input valid, input interval_ticks, output ready);
endinterface

interface med_out_if;
  logic                         valid;
  logic                         ready;
  logic [med_pkg::StatusW-1:0]  status;
  logic [med_pkg::WordBits-1:0] word_data;
  logic                         is_command;

  modport source (output valid, output status, output word_data, output is_command,
                  input ready);
  modport sink (input valid, input status, input word_data, input is_command,
                output ready);
endinterface

// File: hdl/med_cfg_regs.sv
// ----------------------------------------------------------------------------
// med_cfg_regs
// APB register file: bit period and parity seed, plus derived thresholds.
// ----------------------------------------------------------------------------
module med_cfg_regs (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [med_pkg::AddrW-1:0]    paddr,
  input  logic [med_pkg::DataW-1:0]    pwdata,
  output logic [med_pkg::DataW-1:0]    prdata,
  output logic                         pready,
  output med_pkg::thr_t                thr,
  output logic                         init_parity
);

  logic [med_pkg::PeriodW-1:0] period_r, period_nxt;
  logic                        parity_r, parity_nxt;
  med_pkg::thr_t               thr_r, thr_nxt;
  logic                        wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;

  // Decode writes; thresholds follow the period
  always_comb begin
    period_nxt = period_r;
    parity_nxt = parity_r;
    thr_nxt    = thr_r;
    if (wr_en) begin
      case (paddr[2])
        med_pkg::REG_BIT_PERIOD: begin
          period_nxt = pwdata[med_pkg::PeriodW-1:0];
          thr_nxt    = med_pkg::thr_calc(pwdata[med_pkg::PeriodW-1:0]);
        end
        med_pkg::REG_INIT_PARITY: begin
          parity_nxt = pwdata[0];
        end
        default: begin
          period_nxt = period_r;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      period_r <= med_pkg::PeriodReset;
      parity_r <= med_pkg::InitParityReset;
      thr_r    <= med_pkg::thr_calc(med_pkg::PeriodReset);
    end else begin
      period_r <= period_nxt;
      parity_r <= parity_nxt;
      thr_r    <= thr_nxt;
    end
  end

  // Read back
  always_comb begin
    case (paddr[2])
      med_pkg::REG_BIT_PERIOD:  prdata = med_pkg::DataW'(period_r);
      med_pkg::REG_INIT_PARITY: prdata = med_pkg::DataW'(parity_r);
      default:                  prdata = '0;
    endcase
  end

  assign thr         = thr_r;
  assign init_parity = parity_r;

endmodule

// File: hdl/med_classifier.sv
// ----------------------------------------------------------------------------
// med_classifier
// Front end: accepts interval beats and sorts them into classes.
// ----------------------------------------------------------------------------
module med_classifier (
  med_in_if.sink                    in_ch,
  input  med_pkg::thr_t             thr,
  input  med_pkg::q_status_t        q_st,
  output logic                      push,
  output med_pkg::class_t           push_cls
);

  logic [med_pkg::ScaledW-1:0] scaled;

  // Take a beat whenever the queue has room
  assign in_ch.ready = ~q_st.full;
  assign push        = in_ch.valid & ~q_st.full;

  assign scaled = med_pkg::ScaledW'(in_ch.interval_ticks) * med_pkg::ScaledW'(100);

  // Compare 100*ticks against the period multiples
  always_comb begin
    if (scaled < thr.t26 || scaled >= thr.t226) begin
      push_cls = med_pkg::CLS_LEN_ERR;
    end else if (scaled < thr.t76) begin
      push_cls = med_pkg::CLS_HALF;
    end else if (scaled < thr.t126) begin
      push_cls = med_pkg::CLS_FULL;
    end else if (scaled < thr.t176) begin
      push_cls = med_pkg::CLS_SYNC_15;
    end else begin
      push_cls = med_pkg::CLS_SYNC_2;
    end
  end

endmodule

// File: hdl/med_class_fifo.sv
// ----------------------------------------------------------------------------
// med_class_fifo
// Short queue of interval classes between the front and back ends.
// ----------------------------------------------------------------------------
module med_class_fifo (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  input  med_pkg::class_t      push_cls,
  input  logic                 pop,
  output med_pkg::class_t      head_cls,
  output med_pkg::q_status_t   q_st
);

  med_pkg::class_t             mem_r [med_pkg::QDepth];
  logic [med_pkg::QPtrW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [med_pkg::QPtrW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [med_pkg::QCntW-1:0]   cnt_r, cnt_nxt;

  // Advance pointers and count
  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Store entries
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_cls;
    end
  end

  assign head_cls      = mem_r[rd_ptr_r];
  assign q_st.full     = (cnt_r == med_pkg::QCntW'(med_pkg::QDepth));
  assign q_st.nonempty = (cnt_r != '0);

endmodule

// File: hdl/med_decoder.sv
// ----------------------------------------------------------------------------
// med_decoder
// Back end: tracks line level and framing, shifts in bits, checks parity.
// ----------------------------------------------------------------------------
module med_decoder (
  input  logic                 clk,
  input  logic                 rst_n,
  input  med_pkg::class_t      head_cls,
  input  med_pkg::q_status_t   q_st,
  input  logic                 init_parity,
  output logic                 pop,
  med_out_if.source            out_ch
);

  // Decoder state
  logic                          level_r, level_nxt;
  logic [1:0]                    half_r, half_nxt;
  logic [med_pkg::BitCntW-1:0]   bcnt_r, bcnt_nxt;
  logic                          in_word_r, in_word_nxt;
  logic [med_pkg::WordBits-1:0]  shift_r, shift_nxt;
  logic                          par_r, par_nxt;
  logic                          pend_cmd_r, pend_cmd_nxt;
  logic [med_pkg::WordBits-1:0]  word_r, word_nxt;
  logic                          cmd_r, cmd_nxt;

  // Output register
  logic                          out_valid_r, out_valid_nxt;
  med_pkg::status_t              out_status_r;
  logic [med_pkg::WordBits-1:0]  out_word_r;
  logic                          out_cmd_r;

  med_pkg::status_t              st;
  logic [2:0]                    hb;
  logic                          len_err;
  logic                          flip;

  // Load a new result when the output register is free or being drained
  assign pop = q_st.nonempty & (~out_valid_r | out_ch.ready);

  // Apply one interval class to the decoder state
  always_comb begin
    level_nxt    = ~level_r;
    hb           = {1'b0, half_r};
    in_word_nxt  = in_word_r;
    shift_nxt    = shift_r;
    par_nxt      = par_r;
    bcnt_nxt     = bcnt_r;
    pend_cmd_nxt = pend_cmd_r;
    word_nxt     = word_r;
    cmd_nxt      = cmd_r;
    st           = med_pkg::ST_WAIT;
    len_err      = 1'b0;
    flip         = 1'b0;

    case (head_cls)
      med_pkg::CLS_HALF: begin
        hb = hb + 3'd1;
      end
      med_pkg::CLS_FULL: begin
        hb = hb + 3'd2;
      end
      med_pkg::CLS_SYNC_15, med_pkg::CLS_SYNC_2: begin
        in_word_nxt  = 1'b1;
        shift_nxt    = '0;
        par_nxt      = init_parity;
        bcnt_nxt     = '0;
        hb           = (head_cls == med_pkg::CLS_SYNC_15) ? 3'd1 : 3'd2;
        pend_cmd_nxt = ~level_nxt;
      end
      default: begin
        len_err = 1'b1;
      end
    endcase

    if (len_err) begin
      // Drop framing on a bad interval
      bcnt_nxt    = '0;
      hb          = '0;
      in_word_nxt = 1'b0;
      st          = med_pkg::ST_ERR_LEN;
    end else if (hb >= 3'd3) begin
      bcnt_nxt    = '0;
      hb          = '0;
      in_word_nxt = 1'b0;
      st          = med_pkg::ST_ERR_STRUCT;
    end else if (!in_word_nxt) begin
      st = med_pkg::ST_WAIT;
    end else if (hb == 3'd2) begin
      if (bcnt_nxt < med_pkg::WordCnt) begin
        // Shift in one data bit, MSB first
        shift_nxt = {shift_nxt[med_pkg::WordBits-2:0], level_nxt};
        par_nxt   = par_nxt ^ level_nxt;
        bcnt_nxt  = bcnt_nxt + 1'b1;
        hb        = '0;
        st        = (bcnt_nxt < med_pkg::WordCnt) ? med_pkg::ST_BITS : med_pkg::ST_PARITY;
      end else begin
        // Parity bit: a mismatch means the polarity was read inverted
        flip         = level_nxt ^ par_nxt;
        word_nxt     = shift_nxt ^ {med_pkg::WordBits{flip}};
        cmd_nxt      = pend_cmd_nxt ^ flip;
        level_nxt    = level_nxt ^ flip;
        shift_nxt    = '0;
        pend_cmd_nxt = 1'b0;
        bcnt_nxt     = '0;
        hb           = '0;
        in_word_nxt  = 1'b0;
        st           = med_pkg::ST_READY;
      end
    end else begin
      st = (bcnt_nxt < med_pkg::WordCnt) ? med_pkg::ST_BITS : med_pkg::ST_PARITY;
    end

    half_nxt = hb[1:0];
  end

  // Hold or drain the output beat
  always_comb begin
    if (pop) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      level_r      <= 1'b0;
      half_r       <= '0;
      bcnt_r       <= '0;
      in_word_r    <= 1'b0;
      shift_r      <= '0;
      par_r        <= 1'b0;
      pend_cmd_r   <= 1'b0;
      word_r       <= '0;
      cmd_r        <= 1'b0;
      out_valid_r  <= 1'b0;
      out_status_r <= med_pkg::ST_WAIT;
      out_word_r   <= '0;
      out_cmd_r    <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (pop) begin
        level_r      <= level_nxt;
        half_r       <= half_nxt;
        bcnt_r       <= bcnt_nxt;
        in_word_r    <= in_word_nxt;
        shift_r      <= shift_nxt;
        par_r        <= par_nxt;
        pend_cmd_r   <= pend_cmd_nxt;
        word_r       <= word_nxt;
        cmd_r        <= cmd_nxt;
        out_status_r <= st;
        out_word_r   <= word_nxt;
        out_cmd_r    <= cmd_nxt;
      end
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.status     = out_status_r;
  assign out_ch.word_data  = out_word_r;
  assign out_ch.is_command = out_cmd_r;

endmodule

// File: hdl/manchester_edge_interval_decoder.sv
// ----------------------------------------------------------------------------
// manchester_edge_interval_decoder
// Manchester II word receiver driven by measured edge-to-edge intervals.
// ----------------------------------------------------------------------------
// Each input beat is the tick count between two line edges and yields exactly
// one result beat: a status code plus the last completed word and its command
// flag. The block takes one beat per clock while the class queue has room. A
// beat is classified against the configured bit period in the cycle it is
// accepted and lands in a two-entry class queue; the decoder pops one class
// per cycle into the output register while that register is free or being
// drained. With the output stalled, the queue absorbs two more beats before
// input ready drops.
// Write bit_period_ticks and initial_parity only while no beat is in flight.
// ----------------------------------------------------------------------------
module manchester_edge_interval_decoder (
  input  logic                       clk,
  input  logic                       rst_n,
  med_in_if.sink                     in_ch,
  med_out_if.source                  out_ch,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [med_pkg::AddrW-1:0]  paddr,
  input  logic [med_pkg::DataW-1:0]  pwdata,
  output logic [med_pkg::DataW-1:0]  prdata,
  output logic                       pready
);

  med_pkg::thr_t       thr;
  logic                init_parity;
  med_pkg::q_status_t  q_st;
  logic                push;
  logic                pop;
  med_pkg::class_t     push_cls;
  med_pkg::class_t     head_cls;

  med_cfg_regs u_cfg (
    .clk         (clk),
    .rst_n       (rst_n),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .thr         (thr),
    .init_parity (init_parity)
  );

  med_classifier u_front (
    .in_ch    (in_ch),
    .thr      (thr),
    .q_st     (q_st),
    .push     (push),
    .push_cls (push_cls)
  );

  med_class_fifo u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_cls (push_cls),
    .pop      (pop),
    .head_cls (head_cls),
    .q_st     (q_st)
  );

  med_decoder u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .head_cls    (head_cls),
    .q_st        (q_st),
    .init_parity (init_parity),
    .pop         (pop),
    .out_ch      (out_ch)
  );

  // Never pop an empty queue
  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> q_st.nonempty)
    else $error("class queue popped while empty");

  // Input backpressure only follows a stalled output beat
  a_bp_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ch.ready |-> $past(out_ch.valid && !out_ch.ready))
    else $error("input stalled without output backpressure");

  // Reported word changes only with a word-ready status
  a_word_on_ready: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && !$stable(out_ch.word_data)) |-> (out_ch.status == med_pkg::ST_READY))
    else $error("word changed without word-ready status");

endmodule
